@@ hdl/lug_pkg.sv @@
// Shared types and constants for the Lehmer uniform integer generator.
// Used by lug_ctrl, lug_datapath and the top level; no dependencies.
package lug_pkg;

    localparam int STATE_W = 31;
    localparam int LIMIT_W = 16;
    localparam int MULT_W  = 15;
    localparam int SPAN_W  = LIMIT_W + 1;
    localparam int PROD_W  = STATE_W + MULT_W;
    localparam int SCALE_W = STATE_W + SPAN_W;

    localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
    localparam logic [STATE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] STATE_RESET = 31'd123456789;

    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } lug_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic fold;
        logic scale;
        logic div;
        logic finish;
    } lug_cmd_t;

    typedef struct packed {
        logic bypass;    // incoming item needs no arithmetic (load, or zero state)
        logic out_busy;  // output register holds a result that is not taken this cycle
    } lug_stat_t;

endpackage

@@ hdl/lug_ctrl.sv @@
// Sequencer for the generator: walks one item through multiply, fold,
// scale and divide steps, or straight to the finish for loads and zero-state draws. Depends on lug_pkg.
module lug_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  lug_pkg::lug_stat_t stat,
    output lug_pkg::lug_cmd_t  cmd
);

    lug_pkg::lug_state_t state_reg;
    lug_pkg::lug_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lug_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            lug_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.bypass ? lug_pkg::ST_DONE : lug_pkg::ST_MUL;
                end
            end
            lug_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = lug_pkg::ST_FOLD;
            end
            lug_pkg::ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = lug_pkg::ST_SCALE;
            end
            lug_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = lug_pkg::ST_DIV;
            end
            lug_pkg::ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = lug_pkg::ST_DONE;
            end
            lug_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = lug_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lug_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/lug_datapath.sv @@
// Datapath: generator state, constant multiply with Mersenne fold, span
// scaling, division by 2^31-1 and the output register. Depends on lug_pkg.
module lug_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lug_pkg::lug_cmd_t             cmd,
    output lug_pkg::lug_stat_t            stat,
    input  logic [63:0]                   s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lug_pkg::LIMIT_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tuser
);

    localparam int SW = lug_pkg::STATE_W;
    localparam int LW = lug_pkg::LIMIT_W;
    localparam int PW = lug_pkg::SPAN_W;

    // unpacked input fields
    logic [SW-1:0]        seed_in;
    logic signed [LW-1:0] lim_a;
    logic signed [LW-1:0] lim_b;
    logic signed [LW-1:0] lo_in;
    logic signed [LW-1:0] hi_in;
    logic [PW-1:0]        span_in;

    logic [SW-1:0]                  state_reg;
    logic [SW-1:0]                  seed_reg;
    logic signed [LW-1:0]           lo_reg;
    logic signed [LW-1:0]           hi_reg;
    logic [PW-1:0]                  span_reg;
    logic                           load_reg;
    logic                           zero_reg;
    logic [lug_pkg::PROD_W-1:0]     prod_reg;
    logic [SW-1:0]                  s_reg;
    logic [lug_pkg::SCALE_W-1:0]    scaled_reg;
    logic [PW-1:0]                  off_reg;
    logic [LW-1:0]                  out_value_reg;
    logic                           out_err_reg;
    logic                           out_valid_reg;

    logic [SW:0]                    fold_sum;
    logic [SW-1:0]                  s_next;
    logic [PW-1:0]                  quo;
    logic [SW:0]                    rem;
    logic [PW-1:0]                  off_next;
    logic signed [PW:0]             draw_sum;
    logic signed [LW-1:0]           draw_value;
    logic [LW-1:0]                  out_value_next;

    assign seed_in = s_axis_tdata[SW-1:0];
    assign lim_a   = s_axis_tdata[SW+LW-1:SW];
    assign lim_b   = s_axis_tdata[SW+2*LW-1:SW+LW];
    assign lo_in   = (lim_b < lim_a) ? lim_b : lim_a;
    assign hi_in   = (lim_b < lim_a) ? lim_a : lim_b;
    assign span_in = PW'($signed({hi_in[LW-1], hi_in}) - $signed({lo_in[LW-1], lo_in}))
                     + PW'(1);

    assign stat.bypass   = (s_axis_tuser == lug_pkg::MODE_LOAD) || (state_reg == '0);
    assign stat.out_busy = out_valid_reg && !m_axis_tready;

    // x mod (2^31-1): add the high bits back onto the low bits, one correction
    assign fold_sum = {1'b0, prod_reg[SW-1:0]} + (SW+1)'(prod_reg[lug_pkg::PROD_W-1:SW]);
    assign s_next   = (fold_sum >= {1'b0, lug_pkg::LEHMER_MOD})
                      ? SW'(fold_sum - {1'b0, lug_pkg::LEHMER_MOD}) : SW'(fold_sum);

    // floor(x / (2^31-1)): x = q*2^31 + l = q*M + (q + l)
    assign quo      = scaled_reg[lug_pkg::SCALE_W-1:SW];
    assign rem      = {1'b0, scaled_reg[SW-1:0]} + (SW+1)'(quo);
    assign off_next = quo + PW'(rem >= {1'b0, lug_pkg::LEHMER_MOD});

    assign draw_sum   = $signed({{2{lo_reg[LW-1]}}, lo_reg}) + $signed({1'b0, off_reg});
    assign draw_value = (draw_sum > $signed({{2{hi_reg[LW-1]}}, hi_reg}))
                        ? hi_reg : LW'(draw_sum);

    always_comb
    begin
        if (load_reg)
        begin
            out_value_next = '0;
        end
        else if (zero_reg)
        begin
            out_value_next = lo_reg;
        end
        else
        begin
            out_value_next = draw_value;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lug_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                if (load_reg)
                begin
                    state_reg <= seed_reg;
                end
                else if (!zero_reg)
                begin
                    state_reg <= s_reg;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seed_reg <= seed_in;
            lo_reg   <= lo_in;
            hi_reg   <= hi_in;
            span_reg <= span_in;
            load_reg <= (s_axis_tuser == lug_pkg::MODE_LOAD);
            zero_reg <= (state_reg == '0);
        end
        if (cmd.mul)
        begin
            prod_reg <= {{lug_pkg::MULT_W{1'b0}}, state_reg}
                        * {{SW{1'b0}}, lug_pkg::LEHMER_MULT};
        end
        if (cmd.fold)
        begin
            s_reg <= s_next;
        end
        if (cmd.scale)
        begin
            scaled_reg <= {{PW{1'b0}}, s_reg} * {{SW{1'b0}}, span_reg};
        end
        if (cmd.div)
        begin
            off_reg <= off_next;
        end
        if (cmd.finish)
        begin
            out_value_reg <= out_value_next;
            out_err_reg   <= !load_reg && zero_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

@@ hdl/lehmer_uniform_int_generator_core.sv @@
// Top level of the Lehmer uniform integer generator (multiplier 16807,
// modulus 2^31-1). Depends on lug_pkg, lug_ctrl and lug_datapath.
//
// Usage:
//   Input stream (s_axis_*): one item per handshake. tuser is the mode:
//   0 draws a number in [low_limit, high_limit] (limits swapped if reversed),
//   1 loads the generator state from new_seed.
//   Output stream (m_axis_*): exactly one item per input item, in order.
//   tdata is the drawn value (0 for a load), tuser flags a draw from a zero
//   state (the value is then the lower limit and the state stays zero).
// Sequence:
//   A draw that advances the state runs multiply, fold, scale and divide
//   steps in one shared sequencer: the result register loads in the done
//   step that follows the divide step, and the next item is accepted only
//   after that, so items never overlap. Loads and zero-state draws skip the
//   arithmetic and go from the accept straight to the done step.
// Reset: the state becomes 123456789, the sequencer idles, output invalid.
// Stall: a finished result waits in the output register; the next item is
//   still accepted and processed, and holds in its last step until the
//   register is free.
module lehmer_uniform_int_generator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // new_seed[30:0], low_limit[46:31], high_limit[62:47], 0
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value[15:0]
    output logic        m_axis_tuser    // zero_seed_error
);

    lug_pkg::lug_cmd_t  cmd;
    lug_pkg::lug_stat_t stat;

    lug_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lug_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // one item at a time: no accept right after an accept
    a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // at most one datapath step per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.mul, cmd.fold, cmd.scale, cmd.div, cmd.finish}))
        else $error("more than one datapath command active");

    // a finished item always shows up on the output
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished item not presented");

    // the output register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.finish)
        else $error("pending result overwritten");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for lehmer_uniform_int_generator_core: a directed table, then random draws
// and loads under several idle/stall mixes, all checked against a predictor in this file or typed table results.
// Depends on lug_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_top;

    localparam int STATE_W      = lug_pkg::STATE_W;
    localparam int LIMIT_W      = lug_pkg::LIMIT_W;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;      // long output hold-off for backpressure
    localparam int DRAIN_CYCLES = 16;       // margin after the last outstanding result
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 220;
    localparam int PRESS_ITEMS  = 48;
    localparam logic [STATE_W-1:0] SEED_ALL_ONES = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                      mode;
        logic [STATE_W-1:0]        seed;
        logic signed [LIMIT_W-1:0] lo;
        logic signed [LIMIT_W-1:0] hi;
    } gen_item_t;

    typedef struct packed {
        logic signed [LIMIT_W-1:0] value;
        logic                      zero_err;
    } gen_result_t;

    // one row of the directed table; typed = 1 means the result is given in the row
    typedef struct packed {
        logic                      mode;
        logic [STATE_W-1:0]        seed;
        logic signed [LIMIT_W-1:0] lo;
        logic signed [LIMIT_W-1:0] hi;
        logic                      typed;
        logic signed [LIMIT_W-1:0] value;
        logic                      zero_err;
    } dir_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [STATE_W-1:0] lcg_state = lug_pkg::STATE_RESET;
    gen_result_t        pending_results[$];
    dir_row_t           dir_rows[21];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    lehmer_uniform_int_generator_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advances the generator copy by one item and returns the result it yields.
    function automatic gen_result_t lcg_step(input gen_item_t it);
        gen_result_t               res;
        logic signed [LIMIT_W-1:0] lo_v;
        logic signed [LIMIT_W-1:0] hi_v;
        longint                    next_v;
        longint                    span;
        longint                    pick;
        res.value    = '0;
        res.zero_err = 1'b0;
        if (it.mode == lug_pkg::MODE_LOAD)
        begin
            lcg_state = it.seed;
        end
        else
        begin
            lo_v = (it.hi < it.lo) ? it.hi : it.lo;
            hi_v = (it.hi < it.lo) ? it.lo : it.hi;
            if (lcg_state == '0)
            begin
                // stuck state: lower limit, flagged, no advance
                res.value    = lo_v;
                res.zero_err = 1'b1;
            end
            else
            begin
                next_v = (longint'(lcg_state) * longint'(lug_pkg::LEHMER_MULT))
                         % longint'(lug_pkg::LEHMER_MOD);
                span   = longint'(hi_v) - longint'(lo_v) + 1;
                pick   = longint'(lo_v) + (next_v * span) / longint'(lug_pkg::LEHMER_MOD);
                if (pick < longint'(lo_v))
                    pick = longint'(lo_v);
                if (pick > longint'(hi_v))
                    pick = longint'(hi_v);
                res.value = pick[LIMIT_W-1:0];
                lcg_state = next_v[STATE_W-1:0];
            end
        end
        return res;
    endfunction

    // Offers one item, holds it until accepted, then queues its expected result.
    task automatic offer(input gen_item_t it, input logic typed, input gen_result_t typed_res);
        gen_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.hi, it.lo, it.seed};
        s_axis_tuser  <= it.mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = lcg_step(it);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Stops offering and waits for every outstanding result, plus latency margin.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        gen_item_t it;
        int        pick;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            it.mode = ($urandom_range(99) < 14) ? lug_pkg::MODE_LOAD : lug_pkg::MODE_DRAW;
            // seeds: zero and all-ones now and then, otherwise small or full-width
            pick = $urandom_range(15);
            if (pick == 0)
                it.seed = '0;
            else if (pick == 1)
                it.seed = SEED_ALL_ONES;
            else if (pick == 2)
                it.seed = STATE_W'($urandom_range(1000, 1));
            else
                it.seed = STATE_W'($urandom);
            it.lo = LIMIT_W'($urandom);
            case ($urandom_range(3))
                0: it.hi = LIMIT_W'($urandom);
                1: it.hi = it.lo + LIMIT_W'($urandom_range(40));  // narrow span, may wrap
                2: it.hi = it.lo;
                default:
                begin
                    it.lo = ($urandom_range(1)) ? 16'sh8000 : 16'sh7FFF;
                    it.hi = ($urandom_range(1)) ? LIMIT_W'($urandom) : -16'sd1;
                end
            endcase
            offer(it, 1'b0, '0);
        end
    endtask

    // Output sink: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        gen_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: value=%0d zero_seed_error=%0b",
                             $signed(m_axis_tdata), m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.zero_err)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display("mismatch: value exp %0d got %0d, zero_seed_error exp %0b got %0b",
                                 want.value, $signed(m_axis_tdata), want.zero_err, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("lehmer_uniform_int_generator_core test failed");
            $finish;
        end
    end

    initial
    begin
        gen_item_t   it;
        gen_result_t res;
        // mode, seed, lo, hi, typed, value, zero_err
        dir_rows = '{
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd0,    16'sh7FFF, 1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh8000, 16'sh7FFF, 1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh7FFF, 16'sh8000, 1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0},
            '{lug_pkg::MODE_LOAD, 31'd1,         16'sd3,    16'sd9,    1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd0,    16'sd100,  1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_LOAD, 31'h7FFF_FFFE, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh8000, 16'sh7FFF, 1'b0, 16'sd0,    1'b0},
            // zero seed: draws stay stuck at the lower limit with the flag set
            '{lug_pkg::MODE_LOAD, 31'd0,         16'sd0,    16'sd0,    1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd5,    -16'sd7,   1'b1, -16'sd7,   1'b1},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1},
            // all-ones seed folds to zero on the first draw, unflagged
            '{lug_pkg::MODE_LOAD, 31'h7FFF_FFFF, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd9,    -16'sd3,   1'b1, -16'sd3,   1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd100,  16'sd200,  1'b1, 16'sd100,  1'b1},
            '{lug_pkg::MODE_LOAD, 31'h2AAA_AAAA, 16'sh5555, 16'shAAAA, 1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sh5555, 16'shAAAA, 1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_LOAD, 31'h5555_5555, 16'shAAAA, 16'sh5555, 1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         -16'sd1,   16'sd0,    1'b0, 16'sd0,    1'b0},
            '{lug_pkg::MODE_LOAD, 31'd123456789, 16'sd0,    16'sd0,    1'b1, 16'sd0,    1'b0},
            '{lug_pkg::MODE_DRAW, 31'd0,         16'sd1,    16'sd6,    1'b0, 16'sd0,    1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            it.mode      = dir_rows[k].mode;
            it.seed      = dir_rows[k].seed;
            it.lo        = dir_rows[k].lo;
            it.hi        = dir_rows[k].hi;
            res.value    = dir_rows[k].value;
            res.zero_err = dir_rows[k].zero_err;
            offer(it, dir_rows[k].typed, res);
        end
        drain();

        run_phase(PHASE_ITEMS, 0, 0);
        drain();
        run_phase(PHASE_ITEMS, 83, 0);
        drain();
        run_phase(PHASE_ITEMS, 0, 83);
        drain();
        run_phase(PHASE_ITEMS, 6, 6);
        drain();

        // back-to-back offers against a held output: the core fills and stalls its input
        hold_reqs++;
        run_phase(PRESS_ITEMS, 0, 0);
        drain();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("lehmer_uniform_int_generator_core test passed");
        else
            $display("lehmer_uniform_int_generator_core test failed");
        $finish;
    end

endmodule
